// ----- src/newton_divided_difference_interp_unit_defines.svh -----
// Assertion macros used by the checker of this block.
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_UNIT_DEFINES_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define NDI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ndi check failed (same cycle)");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define NDI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ndi check failed (next cycle)");

`endif

// ----- src/ndi_pkg.sv -----
`timescale 1ns / 1ps
package ndi_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int DIV_DEN_W  = DATA_W + 1;
  localparam int DIV_NUM_W  = DIV_DEN_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
  localparam int ACC_W      = DATA_W + CNT_W;
  localparam int TOTAL_W    = 5;
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_EVAL  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    NODE_HOLD  = 2'd0,
    NODE_LEFT  = 2'd1,
    NODE_RIGHT = 2'd2
  } node_op_e;

  typedef struct packed {
    node_op_e node_op;
    logic     rc_shift;
  } cell_ctrl_t;

  // Clamp a signed 64-bit value into the signed data range.
  function automatic logic signed [DATA_W-1:0] sat_to_data(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    r = v[DATA_W-1:0];
    if (!v[63] && (|v[62:DATA_W-1])) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[63] && !(&v[62:DATA_W-1])) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

// ----- src/ndi_cell.sv -----
`timescale 1ns / 1ps
module ndi_cell (
  input  logic                               clk_i,
  input  ndi_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [ndi_pkg::DATA_W-1:0]  node_prev_i,
  input  logic signed [ndi_pkg::DATA_W-1:0]  node_next_i,
  input  logic signed [ndi_pkg::DATA_W-1:0]  row_next_i,
  input  logic signed [ndi_pkg::DATA_W-1:0]  coeff_next_i,
  output logic signed [ndi_pkg::DATA_W-1:0]  node_o,
  output logic signed [ndi_pkg::DATA_W-1:0]  row_o,
  output logic signed [ndi_pkg::DATA_W-1:0]  coeff_o
);
  import ndi_pkg::*;

  logic signed [DATA_W-1:0] node_q, node_d;
  logic signed [DATA_W-1:0] row_q, row_d;
  logic signed [DATA_W-1:0] coeff_q, coeff_d;

  always_comb begin
    node_d = node_q;
    unique case (ctrl_i.node_op)
      NODE_HOLD:  node_d = node_q;
      NODE_LEFT:  node_d = node_next_i;
      NODE_RIGHT: node_d = node_prev_i;
      default:    node_d = node_q;
    endcase
    row_d   = ctrl_i.rc_shift ? row_next_i   : row_q;
    coeff_d = ctrl_i.rc_shift ? coeff_next_i : coeff_q;
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    row_q   <= row_d;
    coeff_q <= coeff_d;
  end

  assign node_o  = node_q;
  assign row_o   = row_q;
  assign coeff_o = coeff_q;

endmodule

// ----- src/ndi_div.sv -----
`timescale 1ns / 1ps
module ndi_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [ndi_pkg::DIV_NUM_W-1:0] num_i,
  input  logic signed [ndi_pkg::DIV_DEN_W-1:0] den_i,
  output logic                                 done_o,
  output logic signed [ndi_pkg::DATA_W-1:0]    quo_o
);
  import ndi_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIV_DEN_W:0]     rem_q, rem_d;
  logic [DIV_NUM_W-1:0]   qn_q, qn_d;
  logic [DIV_DEN_W-1:0]   d_q, d_d;
  logic                   neg_q, neg_d;
  logic [DIV_DEN_W:0]     trial;
  logic [DIV_NUM_W-1:0]   lim;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qn_d   = qn_q;
    d_d    = d_q;
    neg_d  = neg_q;
    trial  = {rem_q[DIV_DEN_W-1:0], qn_q[DIV_NUM_W-1]};
    if (start_i) begin
      neg_d  = num_i[DIV_NUM_W-1] ^ den_i[DIV_DEN_W-1];
      qn_d   = num_i[DIV_NUM_W-1] ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
      d_d    = den_i[DIV_DEN_W-1] ? DIV_DEN_W'(-den_i) : DIV_DEN_W'(den_i);
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(DIV_NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one quotient bit a cycle, restoring form
      if (trial >= {1'b0, d_q}) begin
        rem_d = trial - {1'b0, d_q};
        qn_d  = {qn_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        qn_d  = {qn_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qn_q  <= qn_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  // saturate the magnitude quotient into the signed data range
  always_comb begin
    lim = DIV_NUM_W'({1'b1, {(DATA_W-1){1'b0}}});
    if (neg_q) begin
      quo_o = (qn_q > lim) ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-qn_q[DATA_W-1:0]);
    end else begin
      quo_o = (qn_q >= lim) ? {1'b0, {(DATA_W-1){1'b1}}} : qn_q[DATA_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// ----- src/newton_divided_difference_interp_unit.sv -----
`timescale 1ns / 1ps
// Add with n stored points: duplicate scan, node ring alignment, then n divisions;
//   each division runs on a serial divider, one quotient bit a cycle over 49 bits.
// Evaluate uses one shared 32x32 multiplier. Clear, full and empty answers go straight
//   to the response state; duplicates are answered after the full duplicate scan.
// Throughput: one item at a time; the next beat is taken once the result is parked.
// Reset: point count and handshakes clear at once; table cells hold no reset value.
module newton_divided_difference_interp_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] x_value, [63:32] y_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [36:32] point_total, [39:37] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import ndi_pkg::*;

  // One-hot sequencer. The cells form two rings: the node ring turns either way,
  // the row/coefficient ring turns left only. Both are left at home (cell i holds
  // entry i) whenever the sequencer is idle.
  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_DUP    = 13'h0002,
    S_ALIGN  = 13'h0004,
    S_DSTART = 13'h0008,
    S_DWAIT  = 13'h0010,
    S_ROWW   = 13'h0020,
    S_FIN    = 13'h0040,
    S_ELOAD  = 13'h0080,
    S_EMUL   = 13'h0100,
    S_ESHIFT = 13'h0200,
    S_EBACK  = 13'h0400,
    S_EACC   = 13'h0800,
    S_RESP   = 13'h1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]         count_q, count_d;   // stored points
  logic [IDX_W-1:0]         nrot_q, nrot_d;     // node ring right turns in the duplicate scan
  logic [CNT_W-1:0]         align_q, align_d;   // node ring turns right before the first division
  logic [IDX_W-1:0]         rr_q, rr_d;         // row ring left turns
  logic [CNT_W-1:0]         k_q, k_d;           // division step
  logic [CNT_W-1:0]         ncnt_q, ncnt_d;     // node ring left offset while evaluating
  logic                     dup_q, dup_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] cur_q, cur_d;       // previous entry of the row being built
  logic signed [DATA_W-1:0] term_q, term_d;
  logic signed [63:0]       prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DATA_W-1:0] res_value_q, res_value_d;
  status_e                  res_status_q, res_status_d;

  logic                     m_valid_q, m_valid_d;
  logic signed [DATA_W-1:0] m_value_q, m_value_d;
  status_e                  m_status_q, m_status_d;
  logic [TOTAL_W-1:0]       m_total_q, m_total_d;

  cell_ctrl_t               ctrl;
  logic                     node_rep;           // write x into the node ring on a right turn
  logic                     row_rep;            // write cur into the row field on a left turn
  logic                     coeff_rep;          // write cur into the coefficient field as well

  logic signed [DATA_W-1:0] node_w  [MAX_POINTS];
  logic signed [DATA_W-1:0] row_w   [MAX_POINTS];
  logic signed [DATA_W-1:0] coeff_w [MAX_POINTS];
  logic signed [DATA_W-1:0] node_in0;
  logic signed [DATA_W-1:0] row_inl;
  logic signed [DATA_W-1:0] coeff_inl;

  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic signed [DIV_DEN_W-1:0] diff_w;
  logic signed [DIV_DEN_W-1:0] den_w;
  logic signed [DIV_NUM_W-1:0] num_w;
  logic signed [DIV_DEN_W-1:0] fdiff_w;
  logic signed [DATA_W-1:0] f_w;
  logic signed [63:0]       mul_w;
  logic signed [63:0]       shr_w;
  logic                     dup_hit;
  logic                     accept;
  logic [IDX_W-1:0]         rr_inc;
  logic [IDX_W-1:0]         nrot_inc;

  // Ring wiring: the node ring closes through node_in0, the row ring through row_inl.
  assign node_in0  = node_rep  ? x_q   : node_w[MAX_POINTS-1];
  assign row_inl   = row_rep   ? cur_q : row_w[0];
  assign coeff_inl = coeff_rep ? cur_q : coeff_w[0];

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int Prev = (i + MAX_POINTS - 1) % MAX_POINTS;
    localparam int Next = (i + 1) % MAX_POINTS;
    logic signed [DATA_W-1:0] node_prev;
    logic signed [DATA_W-1:0] row_next;
    logic signed [DATA_W-1:0] coeff_next;
    if (i == 0) begin : g_head
      assign node_prev = node_in0;
    end else begin : g_body
      assign node_prev = node_w[Prev];
    end
    if (i == MAX_POINTS - 1) begin : g_tail
      assign row_next   = row_inl;
      assign coeff_next = coeff_inl;
    end else begin : g_mid
      assign row_next   = row_w[Next];
      assign coeff_next = coeff_w[Next];
    end
    ndi_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .node_prev_i  (node_prev),
      .node_next_i  (node_w[Next]),
      .row_next_i   (row_next),
      .coeff_next_i (coeff_next),
      .node_o       (node_w[i]),
      .row_o        (row_w[i]),
      .coeff_o      (coeff_w[i])
    );
  end

  // Divided difference: ((r[k-1] - last_row[k-1]) << 16) / (x - node[n-k]).
  // The row head is cell 0, the node head for the division is the last cell.
  assign diff_w = DIV_DEN_W'(cur_q) - DIV_DEN_W'(row_w[0]);
  assign den_w  = DIV_DEN_W'(x_q) - DIV_DEN_W'(node_w[MAX_POINTS-1]);
  assign num_w  = {diff_w, {FRAC_W{1'b0}}};
  assign div_start = (state_q == S_DSTART);

  ndi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Evaluate factor uses cell 0 of the node ring while it turns left.
  assign fdiff_w = DIV_DEN_W'(x_q) - DIV_DEN_W'(node_w[0]);
  assign f_w     = sat_to_data(64'(fdiff_w));
  assign mul_w   = term_q * f_w;
  assign shr_w   = prod_q >>> FRAC_W;

  assign dup_hit = (node_w[MAX_POINTS-1] == x_q) &&
                   ((CNT_W'(MAX_POINTS - 1) - CNT_W'(nrot_q)) < count_q);

  assign rr_inc   = (rr_q == IDX_W'(MAX_POINTS - 1)) ? '0 : rr_q + 1'b1;
  assign nrot_inc = (nrot_q == IDX_W'(MAX_POINTS - 1)) ? '0 : nrot_q + 1'b1;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    nrot_d       = nrot_q;
    align_d      = align_q;
    rr_d         = rr_q;
    k_d          = k_q;
    ncnt_d       = ncnt_q;
    dup_d        = dup_q;
    x_d          = x_q;
    cur_d        = cur_q;
    term_d       = term_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q;
    m_value_d    = m_value_q;
    m_status_d   = m_status_q;
    m_total_d    = m_total_q;
    ctrl         = '{node_op: NODE_HOLD, rc_shift: 1'b0};
    node_rep     = 1'b0;
    row_rep      = 1'b0;
    coeff_rep    = 1'b0;

    // drop the parked beat once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          x_d          = s_axis_tdata[DATA_W-1:0];
          cur_d        = s_axis_tdata[2*DATA_W-1:DATA_W];
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          unique case (s_axis_tuser)
            ACT_ADD: begin
              if (count_q == CNT_W'(MAX_POINTS)) begin
                res_status_d = ST_FULL;
              end else begin
                dup_d   = 1'b0;
                nrot_d  = '0;
                state_d = S_DUP;
              end
            end
            ACT_EVAL: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                acc_d   = '0;
                state_d = S_ELOAD;
              end
            end
            ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // unused code: answer and leave the table alone
            end
          endcase
        end
      end

      S_DUP: begin
        // one full right turn, comparing every stored node at the last cell
        ctrl.node_op = NODE_RIGHT;
        dup_d  = dup_q || dup_hit;
        nrot_d = nrot_inc;
        if (nrot_q == IDX_W'(MAX_POINTS - 1)) begin
          if (dup_q || dup_hit) begin
            res_status_d = ST_DUP;
            state_d      = S_RESP;
          end else begin
            align_d = CNT_W'(MAX_POINTS) - count_q;
            state_d = S_ALIGN;
          end
        end
      end

      S_ALIGN: begin
        // the last align turn moves entry n out of the last cell: store x there
        ctrl.node_op = NODE_RIGHT;
        node_rep     = (align_q == CNT_W'(1));
        align_d      = align_q - 1'b1;
        if (align_q == CNT_W'(1)) begin
          k_d     = CNT_W'(1);
          state_d = (count_q == '0) ? S_ROWW : S_DSTART;
        end
      end

      S_DSTART: begin
        state_d = S_DWAIT;
      end

      S_DWAIT: begin
        if (div_done) begin
          // retire r[k-1] into the row ring, advance both heads
          ctrl.node_op  = NODE_RIGHT;
          ctrl.rc_shift = 1'b1;
          row_rep       = 1'b1;
          rr_d          = rr_inc;
          cur_d         = div_quo;
          if (k_q == count_q) begin
            state_d = S_ROWW;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_DSTART;
          end
        end
      end

      S_ROWW: begin
        // last row entry is also the new coefficient
        ctrl.rc_shift = 1'b1;
        row_rep       = 1'b1;
        coeff_rep     = 1'b1;
        rr_d          = rr_inc;
        count_d       = count_q + 1'b1;
        res_value_d   = cur_q;
        res_status_d  = ST_OK;
        state_d       = S_FIN;
      end

      S_FIN: begin
        // turn the row ring home
        if (rr_q == '0) begin
          state_d = S_RESP;
        end else begin
          ctrl.rc_shift = 1'b1;
          rr_d          = rr_inc;
        end
      end

      S_ELOAD: begin
        term_d  = coeff_w[0];
        ncnt_d  = '0;
        state_d = (rr_q == '0) ? S_EACC : S_EMUL;
      end

      S_EMUL: begin
        prod_d       = mul_w;
        ctrl.node_op = NODE_LEFT;
        ncnt_d       = ncnt_q + 1'b1;
        state_d      = S_ESHIFT;
      end

      S_ESHIFT: begin
        term_d  = sat_to_data(shr_w);
        state_d = (ncnt_q == CNT_W'(rr_q)) ? S_EBACK : S_EMUL;
      end

      S_EBACK: begin
        // undo the left turns of this term
        ctrl.node_op = NODE_RIGHT;
        ncnt_d       = ncnt_q - 1'b1;
        if (ncnt_q == CNT_W'(1)) begin
          state_d = S_EACC;
        end
      end

      S_EACC: begin
        acc_d         = acc_q + ACC_W'(term_q);
        ctrl.rc_shift = 1'b1;
        rr_d          = rr_inc;
        if (CNT_W'(rr_q) + 1'b1 == count_q) begin
          res_value_d  = sat_to_data(64'(acc_d));
          res_status_d = ST_OK;
          state_d      = S_FIN;
        end else begin
          state_d = S_ELOAD;
        end
      end

      S_RESP: begin
        // park the result once the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_value_d  = res_value_q;
          m_status_d = res_status_q;
          m_total_d  = TOTAL_W'(count_q);
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      nrot_q    <= '0;
      align_q   <= '0;
      rr_q      <= '0;
      k_q       <= '0;
      ncnt_q    <= '0;
      dup_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      nrot_q    <= nrot_d;
      align_q   <= align_d;
      rr_q      <= rr_d;
      k_q       <= k_d;
      ncnt_q    <= ncnt_d;
      dup_q     <= dup_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    cur_q        <= cur_d;
    term_q       <= term_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    m_value_q    <= m_value_d;
    m_status_q   <= m_status_d;
    m_total_q    <= m_total_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_total_q, m_value_q};
  assign m_axis_tuser  = m_status_q;

endmodule

// ----- src/ndi_checker.sv -----
`timescale 1ns / 1ps
`include "newton_divided_difference_interp_unit_defines.svh"
module ndi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import ndi_pkg::*;

  // an accepted beat leaves the input not ready in the next cycle
  `NDI_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // an empty-table answer reports no stored points
  `NDI_ASSERT_NOW(a_empty_total, m_axis_tvalid && m_axis_tuser == ST_EMPTY, m_axis_tdata[36:32] == 5'd0)
  // a full-table answer reports the capacity
  `NDI_ASSERT_NOW(a_full_total, m_axis_tvalid && m_axis_tuser == ST_FULL, m_axis_tdata[36:32] == TOTAL_W'(MAX_POINTS))
  // rejected items carry a zero value
  `NDI_ASSERT_NOW(a_reject_zero, m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_DUP || m_axis_tuser == ST_EMPTY), m_axis_tdata[31:0] == 32'd0)

endmodule

bind newton_divided_difference_interp_unit ndi_checker u_ndi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
